@@ src/lrcpd_pkg.sv @@
`timescale 1ns / 1ps
package lrcpd_pkg;

  localparam int MAX_PAYLOAD = 58;
  localparam int PAY_ADDR_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] CH_START    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_END      = 8'h3C;
  localparam logic [BYTE_W-1:0] COUNT_MAX   = 8'hFF;
  localparam logic [BYTE_W-1:0] GAP_DEFAULT = 8'd10;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TO,
    PH_FROM,
    PH_LEN,
    PH_DATA,
    PH_LRC,
    PH_FOOT
  } phase_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] to_addr;
    logic [BYTE_W-1:0] from_addr;
    logic [LEN_W-1:0]  length;
  } frame_t;

endpackage

@@ src/lrcpd_if.sv @@
`timescale 1ns / 1ps
interface lrcpd_in_if;
  import lrcpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink (input valid, action, rx_byte, output ready);
endinterface

interface lrcpd_out_if;
  import lrcpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] target_address;
  logic [BYTE_W-1:0] source_address;
  logic [LEN_W-1:0]  payload_length;
  logic [LEN_W-1:0]  payload_index;
  logic [BYTE_W-1:0] payload_byte;
  logic              has_payload;
  logic              last;

  modport source (
    output valid, target_address, source_address, payload_length, payload_index,
           payload_byte, has_payload, last,
    input  ready
  );
  modport sink (
    input  valid, target_address, source_address, payload_length, payload_index,
           payload_byte, has_payload, last,
    output ready
  );
endinterface

@@ src/lrcpd_ram.sv @@
`timescale 1ns / 1ps
module lrcpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 58,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/lrcpd_parse.sv @@
`timescale 1ns / 1ps
module lrcpd_parse #(
  parameter int MAX_PAY = lrcpd_pkg::MAX_PAYLOAD,
  parameter int ADDR_W = lrcpd_pkg::PAY_ADDR_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lrcpd_pkg::BYTE_W-1:0] cfg_wdata,
  lrcpd_in_if.sink                   in_ch,
  input  logic                       rd_busy,
  output lrcpd_pkg::frame_t          frame,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  output logic [lrcpd_pkg::BYTE_W-1:0] wr_data
);
  import lrcpd_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [LEN_W-1:0]  byte_pos;
  logic [LEN_W-1:0]  byte_pos_next;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] sum_next;
  logic              checksum_good;
  logic [BYTE_W-1:0] to_addr;
  logic [BYTE_W-1:0] from_addr;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] idle_count;
  logic [BYTE_W-1:0] idle_inc;
  logic [BYTE_W-1:0] gap_limit;
  logic              accept;
  logic              is_byte;
  logic              is_tick;
  logic              gap_hit;
  logic              len_bad;
  logic              abandon;

  assign in_ch.ready   = !rd_busy;
  assign accept        = in_ch.valid && in_ch.ready;
  assign is_byte       = accept && (in_ch.action == ACT_BYTE);
  assign is_tick       = accept && (in_ch.action == ACT_TICK) && (phase != PH_HUNT);
  assign idle_inc      = (idle_count == COUNT_MAX) ? idle_count : idle_count + 8'd1;
  assign gap_hit       = idle_inc >= gap_limit;
  assign len_bad       = in_ch.rx_byte > BYTE_W'(MAX_PAY);
  assign sum_next      = running_sum + in_ch.rx_byte;
  assign byte_pos_next = byte_pos + LEN_W'(1);

  always_comb begin
    phase_next = phase;
    if (is_tick && gap_hit) begin
      phase_next = PH_HUNT;
    end else if (is_byte) begin
      unique case (phase)
        PH_HUNT: if (in_ch.rx_byte == CH_START) phase_next = PH_TO;
        PH_TO:   phase_next = PH_FROM;
        PH_FROM: phase_next = PH_LEN;
        PH_LEN: begin
          if (len_bad) begin
            phase_next = PH_HUNT;
          end else if (in_ch.rx_byte == '0) begin
            phase_next = PH_LRC;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: if (byte_pos_next >= length) phase_next = PH_LRC;
        PH_LRC:  phase_next = PH_FOOT;
        PH_FOOT: if (in_ch.rx_byte == CH_END) phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    wr_en           = is_byte && (phase == PH_DATA);
    wr_addr         = byte_pos[ADDR_W-1:0];
    wr_data         = in_ch.rx_byte;
    frame.start     = is_byte && (phase == PH_FOOT) && (in_ch.rx_byte == CH_END)
                      && checksum_good;
    frame.to_addr   = to_addr;
    frame.from_addr = from_addr;
    frame.length    = length;
    abandon         = (is_tick && gap_hit)
                      || (is_byte && (phase == PH_LEN) && len_bad)
                      || (is_byte && (phase == PH_FOOT) && (in_ch.rx_byte == CH_END));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_pos      <= '0;
      running_sum   <= '0;
      checksum_good <= 1'b0;
      idle_count    <= '0;
      gap_limit     <= GAP_DEFAULT;
      to_addr       <= '0;
      from_addr     <= '0;
      length        <= '0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        gap_limit <= cfg_wdata;
      end
      if (abandon) begin
        byte_pos      <= '0;
        running_sum   <= '0;
        checksum_good <= 1'b0;
        idle_count    <= '0;
      end else if (is_tick) begin
        idle_count <= idle_inc;
      end else if (is_byte) begin
        idle_count <= '0;
        unique case (phase)
          PH_HUNT: begin
            if (in_ch.rx_byte == CH_START) begin
              running_sum   <= '0;
              checksum_good <= 1'b0;
              byte_pos      <= '0;
            end
          end
          PH_TO: begin
            to_addr     <= in_ch.rx_byte;
            running_sum <= sum_next;
          end
          PH_FROM: begin
            from_addr   <= in_ch.rx_byte;
            running_sum <= sum_next;
          end
          PH_LEN: begin
            length      <= in_ch.rx_byte[LEN_W-1:0];
            running_sum <= sum_next;
            byte_pos    <= '0;
          end
          PH_DATA: begin
            running_sum <= sum_next;
            byte_pos    <= byte_pos_next;
          end
          PH_LRC: checksum_good <= ((BYTE_W'(0) - running_sum) == in_ch.rx_byte);
          default: ;
        endcase
      end
    end
  end

endmodule

@@ src/lrcpd_readout.sv @@
`timescale 1ns / 1ps
module lrcpd_readout #(
  parameter int ADDR_W = lrcpd_pkg::PAY_ADDR_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lrcpd_pkg::frame_t            frame,
  output logic                         busy,
  output logic [ADDR_W-1:0]            rd_addr,
  input  logic [lrcpd_pkg::BYTE_W-1:0] rd_data,
  lrcpd_out_if.source                  out_ch
);
  import lrcpd_pkg::*;

  logic [BYTE_W-1:0] to_addr;
  logic [BYTE_W-1:0] from_addr;
  logic [LEN_W-1:0]  length;
  logic [LEN_W-1:0]  issue_idx;
  logic [LEN_W-1:0]  pend_idx;
  logic              pend;
  logic              out_free;
  logic              load_data;
  logic              load_empty;
  logic              can_issue;
  logic              pend_last;

  assign out_free   = !out_ch.valid || out_ch.ready;
  assign pend_last  = pend_idx == (length - LEN_W'(1));
  assign load_data  = busy && pend && out_free;
  assign load_empty = busy && (length == '0) && out_free;
  assign can_issue  = busy && (issue_idx < length) && (!pend || load_data);
  assign rd_addr    = can_issue ? issue_idx[ADDR_W-1:0] : pend_idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend         <= 1'b0;
      issue_idx    <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (frame.start) begin
        busy      <= 1'b1;
        to_addr   <= frame.to_addr;
        from_addr <= frame.from_addr;
        length    <= frame.length;
        issue_idx <= '0;
        pend      <= 1'b0;
      end else begin
        if (can_issue) begin
          pend      <= 1'b1;
          pend_idx  <= issue_idx;
          issue_idx <= issue_idx + LEN_W'(1);
        end else if (load_data) begin
          pend <= 1'b0;
        end
        if ((load_data && pend_last) || load_empty) begin
          busy <= 1'b0;
        end
      end

      if (load_data || load_empty) begin
        out_ch.valid          <= 1'b1;
        out_ch.target_address <= to_addr;
        out_ch.source_address <= from_addr;
        out_ch.payload_length <= length;
        out_ch.payload_index  <= load_data ? pend_idx : '0;
        out_ch.payload_byte   <= load_data ? rd_data : '0;
        out_ch.has_payload    <= load_data;
        out_ch.last           <= load_empty || pend_last;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/lrc_packet_deframer.sv @@
`timescale 1ns / 1ps
// Receive-side deframer for '>' to from len payload lrc '<' frames. Each input word is
// a UART byte or a one-millisecond idle tick. Payload bytes go into a single-port-write
// payload RAM with registered read. On the footer of a frame whose LRC matched, the
// input stalls while the results are read back from the RAM, one result per cycle when
// the output is not held off, and the input stays stalled until the last result has been
// loaded into the single output register. A bad LRC, an oversized length or gap_limit
// idle ticks in a frame drop it without results. gap_limit resets to 10.
module lrc_packet_deframer #(
  parameter int MAX_PAY = lrcpd_pkg::MAX_PAYLOAD,
  parameter int ADDR_W = lrcpd_pkg::PAY_ADDR_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lrcpd_pkg::BYTE_W-1:0] cfg_wdata,
  lrcpd_in_if.sink                     in_ch,
  lrcpd_out_if.source                  out_ch
);
  import lrcpd_pkg::*;

  frame_t            frame;
  logic              rd_busy;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  lrcpd_parse #(
    .MAX_PAY (MAX_PAY),
    .ADDR_W  (ADDR_W)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .rd_busy   (rd_busy),
    .frame     (frame),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  lrcpd_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (MAX_PAY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lrcpd_readout #(
    .ADDR_W (ADDR_W)
  ) u_readout (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .busy    (rd_busy),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/lrc_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
module lrc_packet_deframer_tb;
  import lrcpd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic              act;
    logic [BYTE_W-1:0] data;
  } rx_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] target_address;
    logic [BYTE_W-1:0] source_address;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W-1:0]  payload_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              has_payload;
    logic              last;
  } deframed_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  lrcpd_in_if  in_ch ();
  lrcpd_out_if out_ch ();

  lrc_packet_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  rx_word_t  rx_words[$];
  deframed_t deframed_due[$];
  int        errors = 0;
  int        words_queued = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_reqs = 0;
  int        holds_done = 0;
  int        hold_left = 0;
  int        quiet = 0;
  logic      in_taken = 1'b0;
  logic [BYTE_W-1:0] gap_setting = GAP_DEFAULT;

  // deframer state as the block should hold it
  phase_t            ph;
  logic [LEN_W-1:0]  pos;
  logic [BYTE_W-1:0] sum_acc;
  logic              ck_ok;
  logic [BYTE_W-1:0] to_h;
  logic [BYTE_W-1:0] from_h;
  logic [LEN_W-1:0]  len_h;
  logic [BYTE_W-1:0] pay_mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] idle_cnt;
  logic [BYTE_W-1:0] gap_lim;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic drop_frame();
    ph = PH_HUNT;
    pos = '0;
    sum_acc = '0;
    ck_ok = 1'b0;
    idle_cnt = '0;
  endtask

  task automatic queue_result(logic [LEN_W-1:0] idx, logic [BYTE_W-1:0] data, logic has,
                              logic fin);
    deframed_t r;
    r.target_address = to_h;
    r.source_address = from_h;
    r.payload_length = len_h;
    r.payload_index = idx;
    r.payload_byte = data;
    r.has_payload = has;
    r.last = fin;
    deframed_due.push_back(r);
  endtask

  task automatic deframe_word(logic act, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] lrc_want;
    int i;
    if (act == ACT_TICK) begin
      if (ph != PH_HUNT) begin
        if (idle_cnt < COUNT_MAX) idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt >= gap_lim) drop_frame();
      end
    end else begin
      idle_cnt = '0;
      case (ph)
        PH_HUNT: begin
          if (b == CH_START) begin
            sum_acc = '0;
            ck_ok = 1'b0;
            pos = '0;
            ph = PH_TO;
          end
        end
        PH_TO: begin
          to_h = b;
          sum_acc = sum_acc + b;
          ph = PH_FROM;
        end
        PH_FROM: begin
          from_h = b;
          sum_acc = sum_acc + b;
          ph = PH_LEN;
        end
        PH_LEN: begin
          if (b > MAX_PAYLOAD) begin
            drop_frame();
          end else begin
            len_h = b[LEN_W-1:0];
            sum_acc = sum_acc + b;
            pos = '0;
            ph = (b == 0) ? PH_LRC : PH_DATA;
          end
        end
        PH_DATA: begin
          if (pos < MAX_PAYLOAD) pay_mem[pos] = b;
          sum_acc = sum_acc + b;
          pos = pos + 1'b1;
          if (pos >= len_h) ph = PH_LRC;
        end
        PH_LRC: begin
          lrc_want = 8'd0 - sum_acc;
          ck_ok = (lrc_want == b);
          ph = PH_FOOT;
        end
        PH_FOOT: begin
          if (b == CH_END) begin
            if (ck_ok) begin
              if (len_h == 0) begin
                queue_result('0, '0, 1'b0, 1'b1);
              end else begin
                for (i = 0; i < len_h; i++)
                  queue_result(i[LEN_W-1:0], pay_mem[i], 1'b1, (i + 1 == len_h));
              end
            end
            drop_frame();
          end
        end
        default: drop_frame();
      endcase
    end
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    deframed_t want;
    if (deframed_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, got to %0h from %0h len %0d idx %0d byte %0h",
               $time, out_ch.target_address, out_ch.source_address, out_ch.payload_length,
               out_ch.payload_index, out_ch.payload_byte);
    end else begin
      want = deframed_due.pop_front();
      check_field("target_address", want.target_address, out_ch.target_address);
      check_field("source_address", want.source_address, out_ch.source_address);
      check_field("payload_length", want.payload_length, out_ch.payload_length);
      check_field("payload_index", want.payload_index, out_ch.payload_index);
      check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
      check_field("has_payload", want.has_payload, out_ch.has_payload);
      check_field("last", want.last, out_ch.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      gap_lim = GAP_DEFAULT;
      to_h = '0;
      from_h = '0;
      len_h = '0;
      drop_frame();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we) gap_lim = cfg_wdata;
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) deframe_word(in_ch.action, in_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("lrc_packet_deframer_tb: errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin : drive_words
    rx_word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (rx_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = rx_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= w.act;
        in_ch.rx_byte <= w.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_ch.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_word(logic act, logic [BYTE_W-1:0] b);
    rx_word_t w;
    w.act = act;
    w.data = b;
    rx_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_tick();
    push_word(ACT_TICK, BYTE_W'($urandom_range(255)));
  endtask

  task automatic stray_ticks();
    int r;
    r = $urandom_range(199);
    if (r == 0) begin
      repeat ((gap_setting == 0) ? 1 : int'(gap_setting)) push_tick();
    end else if (r < ((gap_setting > 2) ? 16 : 3)) begin
      repeat ($urandom_range(1, (gap_setting > 2) ? 2 : 1)) push_tick();
    end
  endtask

  task automatic push_frame(logic [BYTE_W-1:0] to_a, logic [BYTE_W-1:0] from_a,
                            logic [BYTE_W-1:0] len, logic [BYTE_W-1:0] pay[$], bit corrupt,
                            int wrong_feet, bit with_ticks);
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    body = {to_a, from_a, len};
    if (len <= MAX_PAYLOAD) body = {body, pay};
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    push_word(ACT_BYTE, CH_START);
    foreach (body[i]) begin
      if (with_ticks) stray_ticks();
      push_word(ACT_BYTE, body[i]);
    end
    if (len <= MAX_PAYLOAD) begin
      b = 8'd0 - sum;
      if (corrupt) b = b ^ (8'h01 << $urandom_range(7));
      if (with_ticks) stray_ticks();
      push_word(ACT_BYTE, b);
      repeat (wrong_feet) begin
        b = BYTE_W'($urandom_range(255));
        push_word(ACT_BYTE, (b == CH_END) ? ~b : b);
      end
      if (with_ticks) stray_ticks();
      push_word(ACT_BYTE, CH_END);
    end
  endtask

  task automatic random_frames(int target);
    logic [BYTE_W-1:0] pay[$];
    int first;
    int len;
    int r;
    first = words_queued;
    while (words_queued - first < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(3) == 0) push_tick();
          else push_word(ACT_BYTE, BYTE_W'($urandom_range(255)));
        end
      end
      r = $urandom_range(99);
      if (r < 5) len = $urandom_range(MAX_PAYLOAD + 1, 255);
      else if (r < 10) len = $urandom_range(20, MAX_PAYLOAD);
      else len = $urandom_range(0, 6);
      pay.delete();
      if (len <= MAX_PAYLOAD) repeat (len) pay.push_back(BYTE_W'($urandom_range(255)));
      push_frame(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), BYTE_W'(len), pay,
                 ($urandom_range(9) == 0), ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0,
                 1'b1);
    end
  endtask

  task automatic settle();
    while (rx_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (deframed_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    gap_setting = v;
  endtask

  initial begin
    logic [BYTE_W-1:0] pay[$];
    logic [BYTE_W-1:0] none[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 32;
    rx_idle_pct = 80;
    push_word(ACT_BYTE, 8'h00);
    push_tick();
    push_frame(8'hFF, 8'h00, 8'd0, none, 1'b0, 0, 1'b0);
    pay = {8'hFF};
    push_frame(8'h00, 8'hFF, 8'd1, pay, 1'b0, 1, 1'b0);
    push_frame(8'h12, 8'h34, 8'(MAX_PAYLOAD + 1), none, 1'b0, 0, 1'b0);
    push_frame(8'h56, 8'h78, 8'd0, none, 1'b1, 0, 1'b0);
    settle();

    write_gap(8'd255);
    pay.delete();
    repeat (MAX_PAYLOAD) pay.push_back(BYTE_W'($urandom_range(255)));
    push_frame(8'hA5, 8'h5A, 8'(MAX_PAYLOAD), pay, 1'b0, 0, 1'b0);
    random_frames(110);
    settle();

    tx_idle_pct = 80;
    rx_idle_pct = 32;
    write_gap(8'd1);
    // drop on the first tick inside a frame
    push_word(ACT_BYTE, CH_START);
    push_word(ACT_BYTE, 8'h11);
    push_tick();
    random_frames(90);
    settle();

    write_gap(8'd0);
    random_frames(60);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_gap(BYTE_W'($urandom_range(2, 254)));
    hold_reqs = hold_reqs + 1;
    pay.delete();
    repeat (12) pay.push_back(BYTE_W'($urandom_range(255)));
    push_frame(8'h01, 8'h02, 8'd12, pay, 1'b0, 0, 1'b0);
    random_frames(110);
    settle();

    if (errors == 0) begin
      $display("lrc_packet_deframer_tb: clean");
    end else begin
      $display("lrc_packet_deframer_tb: errors");
    end
    $finish;
  end

endmodule
